/* design/dtl_pkg.sv */
package dtl_pkg;

	// Request kinds carried on the input tuser field.
	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_DEL  = 2'd1,
		KIND_TICK = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_EMPTY    = 3'd1,
		STAT_EXPIRED  = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_NOTFOUND = 3'd4
	} status_t;

	// Operations of the shared 16-bit delta unit.
	typedef enum logic [1:0] {
		ALU_SUB,
		ALU_ADD_SAT,
		ALU_SUB_SAT
	} alu_op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_WALK,
		S_SHIFT_UP,
		S_INSERT,
		S_DEL_WALK,
		S_SHIFT_DOWN,
		S_TICK,
		S_FINISH,
		S_DONE
	} state_t;

	localparam int unsigned SEQ_W   = 32;
	localparam int unsigned DELTA_W = 16;

	// One timer entry as stored in the list memory.
	typedef struct packed {
		logic [SEQ_W-1:0]   seq;
		logic [DELTA_W-1:0] delta;
	} entry_t;

endpackage

/* design/dtl_alu.sv */
module dtl_alu (
	input  dtl_pkg::alu_op_t                op,
	input  logic [dtl_pkg::DELTA_W-1:0]     a,
	input  logic [dtl_pkg::DELTA_W-1:0]     b,
	output logic [dtl_pkg::DELTA_W-1:0]     res,
	output logic                            ge
);

	logic [dtl_pkg::DELTA_W:0] diff;
	logic [dtl_pkg::DELTA_W:0] sum;

	assign diff = {1'b0, a} - {1'b0, b};
	assign sum  = {1'b0, a} + {1'b0, b};
	// The borrow of the subtraction doubles as the a >= b compare.
	assign ge   = ~diff[dtl_pkg::DELTA_W];

	always_comb begin
		unique case (op)
			dtl_pkg::ALU_SUB:     res = diff[dtl_pkg::DELTA_W-1:0];
			dtl_pkg::ALU_ADD_SAT: res = sum[dtl_pkg::DELTA_W] ? '1 : sum[dtl_pkg::DELTA_W-1:0];
			dtl_pkg::ALU_SUB_SAT: res = ge ? diff[dtl_pkg::DELTA_W-1:0] : '0;
			default:              res = diff[dtl_pkg::DELTA_W-1:0];
		endcase
	end

endmodule

/* design/dtl_ram.sv */
module dtl_ram #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [ADDR_W-1:0]      wr_addr,
	input  dtl_pkg::entry_t        wr_data,
	input  logic [ADDR_W-1:0]      rd_addr,
	output dtl_pkg::entry_t        rd_data
);

	dtl_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* design/delta_timer_list.sv */
// Sorted delta list of up to MAX_TIMERS retransmission timers. Each entry keeps a 32-bit
// sequence number and a 16-bit delay relative to the entry ahead of it, so a tick only
// has to count down the head. One request enters on the slave stream (tuser selects add,
// delete or tick), and exactly one result leaves on the master stream: a status code and
// the sequence number now at the head of the list (zero when the list is empty). The
// entries live in a memory with one write port and one registered read port. Every
// request is worked off one entry per cycle under a small sequencer with one shared
// 16-bit subtract/add unit, and the block takes no new request until the current one is
// finished. An add walks the entries from the head and reads entries 0 to pos, the insert
// point. Unless it lands at the tail (including an add to an empty list, which skips the
// walk), a shift then moves entries count-1 down to pos one place toward the tail, one per
// cycle, with count the fill before the request. A delete walks up to the match and shifts
// the entries behind it, so whether or not it finds a match it touches every entry once.
// A tick on a non-empty list only rewrites the head, and a rejected add, a tick or a
// delete on an empty list, or the unused kind go straight to the finishing states. The
// result becomes valid in the same cycle in which the next request can be taken. The
// result sits in an output register, so the next request is taken while it waits for the
// consumer; the sequencer only stalls, in its last state, when a second result is ready
// before the first has been taken.
module delta_timer_list #(
	parameter int unsigned MAX_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [15:0] timeout, [47:16] seq_number
	input  logic [1:0]  s_axis_tuser,  // [1:0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [2:0] status, [34:3] head_seq, rest zero
);

	localparam int unsigned AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int unsigned CW = $clog2(MAX_TIMERS + 1);

	// Sequencer state and working registers.
	dtl_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    count_q, count_d;
	logic [AW-1:0]    idx_q, idx_d;      // walk position
	logic [AW-1:0]    src_q, src_d;      // shift source address
	logic [AW-1:0]    pos_q, pos_d;      // insert or delete point
	logic [15:0]      rem_q, rem_d;      // remaining delay, or removed delta
	logic [31:0]      seq_q, seq_d;
	dtl_pkg::status_t stat_q, stat_d;

	// Output register.
	logic             out_valid_q;
	logic [39:0]      out_data_q;
	logic             out_load;

	// Memory port.
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	dtl_pkg::entry_t  wr_data;
	logic [AW-1:0]    rd_addr;
	dtl_pkg::entry_t  rd_data;

	// Shared delta unit.
	dtl_pkg::alu_op_t alu_op;
	logic [15:0]      alu_a;
	logic [15:0]      alu_b;
	logic [15:0]      alu_res;
	logic             alu_ge;

	logic             in_fire;
	logic [CW-1:0]    idx_inc;
	logic [CW-1:0]    src_inc;
	logic [CW-1:0]    cnt_m1;
	dtl_pkg::kind_t   in_kind;

	assign in_fire = s_axis_tvalid & s_axis_tready;
	assign in_kind = dtl_pkg::kind_t'(s_axis_tuser);
	assign idx_inc = CW'(idx_q) + CW'(1);
	assign src_inc = CW'(src_q) + CW'(1);
	assign cnt_m1  = count_q - CW'(1);

	dtl_ram #(
		.DEPTH  (MAX_TIMERS),
		.ADDR_W (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dtl_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.ge  (alu_ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtl_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		src_q  <= src_d;
		pos_q  <= pos_d;
		rem_q  <= rem_d;
		seq_q  <= seq_d;
		stat_q <= stat_d;
	end

	// The result is loaded when the sequencer finishes and the register is free or
	// being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {5'd0, (count_q == '0) ? 32'd0 : rd_data.seq, stat_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign s_axis_tready = (state_q == dtl_pkg::S_IDLE);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		src_d    = src_q;
		pos_d    = pos_q;
		rem_d    = rem_q;
		seq_d    = seq_q;
		stat_d   = stat_q;
		out_load = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = pos_q;
		wr_data  = '{seq: seq_q, delta: rem_q};
		rd_addr  = '0;
		alu_op   = dtl_pkg::ALU_SUB;
		alu_a    = rem_q;
		alu_b    = rd_data.delta;

		unique case (state_q)
			dtl_pkg::S_IDLE: begin
				// The head is read here so that its data is ready in the next cycle.
				if (in_fire) begin
					rem_d  = s_axis_tdata[15:0];
					seq_d  = s_axis_tdata[47:16];
					idx_d  = '0;
					pos_d  = '0;
					stat_d = dtl_pkg::STAT_OK;
					unique case (in_kind)
						dtl_pkg::KIND_ADD: begin
							if (count_q == CW'(MAX_TIMERS)) begin
								stat_d  = dtl_pkg::STAT_FULL;
								state_d = dtl_pkg::S_FINISH;
							end else if (count_q == '0) begin
								state_d = dtl_pkg::S_INSERT;
							end else begin
								state_d = dtl_pkg::S_ADD_WALK;
							end
						end
						dtl_pkg::KIND_DEL: begin
							if (count_q == '0) begin
								stat_d  = dtl_pkg::STAT_NOTFOUND;
								state_d = dtl_pkg::S_FINISH;
							end else begin
								state_d = dtl_pkg::S_DEL_WALK;
							end
						end
						dtl_pkg::KIND_TICK: begin
							if (count_q == '0) begin
								stat_d  = dtl_pkg::STAT_EMPTY;
								state_d = dtl_pkg::S_FINISH;
							end else begin
								state_d = dtl_pkg::S_TICK;
							end
						end
						default: begin
							state_d = dtl_pkg::S_FINISH;
						end
					endcase
				end
			end

			dtl_pkg::S_ADD_WALK: begin
				// Entry idx_q is on the read port; the unit checks rem >= delta.
				if (alu_ge) begin
					rem_d = alu_res;
					if (idx_inc == count_q) begin
						pos_d   = idx_inc[AW-1:0];
						state_d = dtl_pkg::S_INSERT;
					end else begin
						idx_d   = idx_inc[AW-1:0];
						rd_addr = idx_inc[AW-1:0];
					end
				end else begin
					pos_d   = idx_q;
					src_d   = cnt_m1[AW-1:0];
					rd_addr = cnt_m1[AW-1:0];
					state_d = dtl_pkg::S_SHIFT_UP;
				end
			end

			dtl_pkg::S_SHIFT_UP: begin
				// Move entry src_q one place toward the tail. The entry that ends up
				// behind the new timer gives up the new timer's remaining delay.
				alu_a   = rd_data.delta;
				alu_b   = rem_q;
				wr_en   = 1'b1;
				wr_addr = src_inc[AW-1:0];
				wr_data = '{seq: rd_data.seq,
				            delta: (src_q == pos_q) ? alu_res : rd_data.delta};
				if (src_q == pos_q) begin
					state_d = dtl_pkg::S_INSERT;
				end else begin
					src_d   = src_q - AW'(1);
					rd_addr = src_q - AW'(1);
				end
			end

			dtl_pkg::S_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = '{seq: seq_q, delta: rem_q};
				count_d = count_q + CW'(1);
				state_d = dtl_pkg::S_FINISH;
			end

			dtl_pkg::S_DEL_WALK: begin
				if (rd_data.seq == seq_q) begin
					pos_d = idx_q;
					rem_d = rd_data.delta;
					if (idx_inc == count_q) begin
						count_d = cnt_m1;
						state_d = dtl_pkg::S_FINISH;
					end else begin
						src_d   = idx_inc[AW-1:0];
						rd_addr = idx_inc[AW-1:0];
						state_d = dtl_pkg::S_SHIFT_DOWN;
					end
				end else if (idx_inc == count_q) begin
					stat_d  = dtl_pkg::STAT_NOTFOUND;
					state_d = dtl_pkg::S_FINISH;
				end else begin
					idx_d   = idx_inc[AW-1:0];
					rd_addr = idx_inc[AW-1:0];
				end
			end

			dtl_pkg::S_SHIFT_DOWN: begin
				// Move entry src_q one place toward the head. The successor of the
				// removed entry adds the removed delta to its own, saturating.
				alu_op  = dtl_pkg::ALU_ADD_SAT;
				alu_a   = rd_data.delta;
				alu_b   = rem_q;
				wr_en   = 1'b1;
				wr_addr = src_q - AW'(1);
				wr_data = '{seq: rd_data.seq,
				            delta: ((src_q - AW'(1)) == pos_q) ? alu_res : rd_data.delta};
				if (src_inc == count_q) begin
					count_d = cnt_m1;
					state_d = dtl_pkg::S_FINISH;
				end else begin
					src_d   = src_inc[AW-1:0];
					rd_addr = src_inc[AW-1:0];
				end
			end

			dtl_pkg::S_TICK: begin
				// The head delta counts down and stays at zero once expired.
				alu_op  = dtl_pkg::ALU_SUB_SAT;
				alu_a   = rd_data.delta;
				alu_b   = 16'd1;
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '{seq: rd_data.seq, delta: alu_res};
				stat_d  = (alu_res == '0) ? dtl_pkg::STAT_EXPIRED : dtl_pkg::STAT_OK;
				state_d = dtl_pkg::S_FINISH;
			end

			dtl_pkg::S_FINISH: begin
				// Read back the head after the last write of the request.
				state_d = dtl_pkg::S_DONE;
			end

			dtl_pkg::S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = dtl_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = dtl_pkg::S_IDLE;
			end
		endcase
	end

endmodule
